[rtl/mbf_pkg.sv]
// ----------------------------------------------------------------------------
// mbf_pkg
// Shared constants and types for the metaball field block.
// ----------------------------------------------------------------------------
package mbf_pkg;
    localparam int MAX_ELEMENTS = 16;
    localparam int SLOT_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int ENTRY_W = 224;
    localparam int ADDR_W = 5;

    localparam logic [ADDR_W-1:0] REG_THRESHOLD = 5'd0;
    localparam logic [ADDR_W-1:0] REG_MARGIN    = 5'd4;
    localparam logic [ADDR_W-1:0] REG_INVERTED  = 5'd8;
    localparam logic [ADDR_W-1:0] REG_COUNT     = 5'd12;
    localparam logic [ADDR_W-1:0] REG_EPSILON   = 5'd16;

    localparam logic ACT_WRITE = 1'b0;

    localparam logic signed [47:0] MAX48 = 48'sh7FFFFFFFFFFF;
    localparam logic signed [47:0] MIN48 = 48'sh800000000000;

    typedef struct packed {
        logic signed [31:0] threshold;
        logic [15:0]        margin;
        logic               inverted;
        logic [4:0]         count;
        logic [15:0]        epsilon;
    } cfg_t;

    // saturate a wide signed value to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [95:0] v);
        if (v > 96'(MAX48))
            return MAX48;
        else if (v < 96'(MIN48))
            return MIN48;
        else
            return v[47:0];
    endfunction
endpackage

[rtl/mbf_if.sv]
// ----------------------------------------------------------------------------
// mbf_in_if / mbf_out_if
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
interface mbf_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  slot;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0] reach_sq;
    logic signed [31:0] coef_quartic;
    logic signed [31:0] coef_quadratic;
    logic signed [31:0] coef_constant;
    modport source (output valid, action, slot, coord_x, coord_y, coord_z, reach_sq,
                    coef_quartic, coef_quadratic, coef_constant, input ready);
    modport sink (input valid, action, slot, coord_x, coord_y, coord_z, reach_sq,
                  coef_quartic, coef_quadratic, coef_constant, output ready);
endinterface

interface mbf_out_if;
    logic        valid;
    logic        ready;
    logic signed [47:0] density;
    logic        inside_res;
    logic        surface_valid;
    modport source (output valid, density, inside_res, surface_valid, input ready);
    modport sink (input valid, density, inside_res, surface_valid, output ready);
endinterface

[rtl/mbf_ram.sv]
// ----------------------------------------------------------------------------
// mbf_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module mbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

[rtl/mbf_cfg.sv]
// ----------------------------------------------------------------------------
// mbf_cfg
// APB register file for the field configuration.
// ----------------------------------------------------------------------------
module mbf_cfg
    import mbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);
    cfg_t cfg_reg;
    logic wr;

    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= '0;
            cfg_reg.margin    <= '0;
            cfg_reg.inverted  <= 1'b0;
            cfg_reg.count     <= '0;
            cfg_reg.epsilon   <= 16'd1;
        end
        else if (wr)
        begin
            case (paddr)
                REG_THRESHOLD: cfg_reg.threshold <= pwdata;
                REG_MARGIN:    cfg_reg.margin    <= pwdata[15:0];
                REG_INVERTED:  cfg_reg.inverted  <= pwdata[0];
                REG_COUNT:     cfg_reg.count     <= pwdata[4:0];
                REG_EPSILON:   cfg_reg.epsilon   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            REG_THRESHOLD: prdata = cfg_reg.threshold;
            REG_MARGIN:    prdata = {16'd0, cfg_reg.margin};
            REG_INVERTED:  prdata = {31'd0, cfg_reg.inverted};
            REG_COUNT:     prdata = {27'd0, cfg_reg.count};
            REG_EPSILON:   prdata = {16'd0, cfg_reg.epsilon};
            default:       prdata = '0;
        endcase
    end
endmodule

[rtl/mbf_eval.sv]
// ----------------------------------------------------------------------------
// mbf_eval
// Per-element field evaluation: a multi-cycle sequence through one
// shared 33x33 signed multiplier, accumulating density and gradient.
// ----------------------------------------------------------------------------
module mbf_eval
    import mbf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,       // entry data valid this cycle
    input  logic                 clear,       // new query: zero accumulators
    input  logic [ENTRY_W-1:0]   entry,
    input  logic signed [31:0]   qx,
    input  logic signed [31:0]   qy,
    input  logic signed [31:0]   qz,
    output logic                 done,
    output logic signed [47:0]   density,
    output logic signed [47:0]   gx,
    output logic signed [47:0]   gy,
    output logic signed [47:0]   gz
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LAST = 5'd20;

    logic [4:0] step_reg, step_next;
    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic [31:0] reach_reg;
    logic signed [31:0] c0_reg, c1_reg, c2_reg;
    logic [49:0] acc_reg;               // sum of squared differences
    logic ovf_reg;
    logic [31:0] len_reg;
    logic signed [47:0] inner_reg;      // trunc(c0*len/2^16)
    logic signed [50:0] t_reg;          // inner+c1 or weight
    logic [95:0] prod_reg;              // wide magnitude product
    logic neg_reg;
    logic signed [47:0] dens_reg, gx_reg, gy_reg, gz_reg;

    // shared signed multiplier, 33x33
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    assign mp = ma * mb;

    // magnitude pieces of t (50 bits) split into low 25 / high 25
    logic [49:0] t_mag;
    logic [32:0] dsel;
    logic [31:0] d_mag;
    logic signed [32:0] dcur;
    logic [47:0] m48;
    logic signed [47:0] term;
    logic too_big;

    always_comb
    begin
        t_mag = t_reg[50] ? 50'(-t_reg) : 50'(t_reg);
        case (step_reg)
            5'd8, 5'd9, 5'd10, 5'd11: dcur = 33'(len_reg);
            5'd12, 5'd13, 5'd14:      dcur = dx_reg;
            5'd15, 5'd16, 5'd17:      dcur = dy_reg;
            default:                  dcur = dz_reg;
        endcase
        dsel  = dcur[32] ? 33'(-dcur) : 33'(dcur);
        d_mag = dsel[31:0];
        ma = '0;
        mb = '0;
        case (step_reg)
            5'd1: begin ma = dx_reg; mb = dx_reg; end
            5'd2: begin ma = dy_reg; mb = dy_reg; end
            5'd3: begin ma = dz_reg; mb = dz_reg; end
            5'd5: begin ma = 33'(c0_reg); mb = 33'($signed({1'b0, len_reg})); end
            5'd9, 5'd12, 5'd15, 5'd18:
                begin ma = 33'({8'd0, t_mag[24:0]}); mb = 33'({1'b0, d_mag}); end
            5'd10, 5'd13, 5'd16, 5'd19:
                begin ma = 33'({8'd0, t_mag[49:25]}); mb = 33'({1'b0, d_mag}); end
            default: ;
        endcase
        too_big = (prod_reg[95:72] != 0);
        m48 = too_big ? 48'hFFFFFFFFFFFF : prod_reg[71:24];
        if (!neg_reg)
            term = (too_big || m48[47]) ? MAX48 : $signed(m48);
        else if (too_big || m48 > 48'h800000000000)
            term = MIN48;
        else
            term = $signed(-m48);
        step_next = step_reg;
        if (step_reg == S_IDLE)
        begin
            if (start)
                step_next = 5'd1;
        end
        else if (step_reg == S_LAST)
            step_next = S_IDLE;
        else
            step_next = step_reg + 5'd1;
    end

    logic signed [65:0] q_div;
    logic signed [32:0] c2_adj;
    logic signed [32:0] c2_q;
    logic signed [96:0] dsum;
    logic signed [96:0] gsum;
    logic signed [47:0] gsel;
    logic in_d, in_g;

    always_comb
    begin
        // truncate toward zero: divide by 2^16
        q_div = (mp < 0) ? -((-mp) >>> 16) : (mp >>> 16);
        in_d = len_reg < reach_reg;
        in_g = len_reg <= reach_reg;
        // truncate toward zero: bias negative values before the shift
        c2_adj = 33'(c2_reg) + (c2_reg[31] ? 33'sd255 : 33'sd0);
        c2_q   = c2_adj >>> 8;
        dsum = 97'(dens_reg) + 97'(term) + 97'(c2_q);
        case (step_reg)
            5'd14:   gsel = gx_reg;
            5'd17:   gsel = gy_reg;
            default: gsel = gz_reg;
        endcase
        gsum = 97'(gsel) + 97'(term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_IDLE;
        else
            step_reg <= step_next;
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            dens_reg <= '0;
            gx_reg   <= '0;
            gy_reg   <= '0;
            gz_reg   <= '0;
        end
        case (step_reg)
            S_IDLE:
                if (start)
                begin
                    dx_reg    <= 33'(qx) - 33'($signed(entry[31:0]));
                    dy_reg    <= 33'(qy) - 33'($signed(entry[63:32]));
                    dz_reg    <= 33'(qz) - 33'($signed(entry[95:64]));
                    reach_reg <= entry[127:96];
                    c0_reg    <= entry[159:128];
                    c1_reg    <= entry[191:160];
                    c2_reg    <= entry[223:192];
                    acc_reg   <= '0;
                    ovf_reg   <= 1'b0;
                end
            5'd1, 5'd2, 5'd3:
            begin
                // each square is below 2^66; saturate when it reaches 2^48
                if (mp[65:48] != 0)
                    ovf_reg <= 1'b1;
                acc_reg <= acc_reg + 50'(mp[47:0]);
            end
            5'd4:
            begin
                if (ovf_reg || acc_reg[49:16] > 34'hFFFFFFFF)
                    len_reg <= 32'hFFFFFFFF;
                else
                    len_reg <= acc_reg[47:16];
            end
            5'd5: inner_reg <= 48'(q_div);
            5'd6: t_reg <= 51'(inner_reg) + 51'(c1_reg);
            5'd7, 5'd11:
            begin
                neg_reg  <= t_reg[50];
                prod_reg <= '0;
            end
            5'd9, 5'd12, 5'd15, 5'd18:
            begin
                prod_reg <= 96'(mp[57:0]);
                neg_reg  <= t_reg[50] ^ dcur[32];
            end
            5'd10, 5'd13, 5'd16, 5'd19:
                prod_reg <= prod_reg + (96'(mp[57:0]) << 25);
            default: ;
        endcase
        if (step_reg == 5'd11)
        begin
            if (in_d)
                dens_reg <= sat48(96'(dsum));
            // weight = -(4*inner + 2*c1)
            t_reg <= -((51'(inner_reg) <<< 2) + (51'(c1_reg) <<< 1));
        end
        if (step_reg == 5'd14 && in_g) gx_reg <= sat48(96'(gsum));
        if (step_reg == 5'd17 && in_g) gy_reg <= sat48(96'(gsum));
        if (step_reg == 5'd20 && in_g) gz_reg <= sat48(96'(gsum));
    end

    assign done    = (step_reg == S_LAST);
    assign density = dens_reg;
    assign gx      = gx_reg;
    assign gy      = gy_reg;
    assign gz      = gz_reg;
endmodule

[rtl/metaball_field_and_surface_test.sv]
// ----------------------------------------------------------------------------
// metaball_field_and_surface_test
// Metaball density field and gradient surface test over a blob table.
// ----------------------------------------------------------------------------
// A write word stores one element (center, squared reach, three
// coefficients) in one 224-bit RAM row and returns a zero result through
// the ST_WAIT state. A query walks the active slots in order; each element
// has its table row fetched and then runs through the evaluator, which shares
// one 33x33 multiplier over the squared distance, the quartic term, the
// density product and the three gradient products, so that multiplier
// sequence sets the query time; one item is in work at a time. The result
// sits in an output register, so the next word is taken as soon as the
// result has been handed off. The table has no reset.
module metaball_field_and_surface_test
    import mbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    mbf_in_if.sink            in_ch,
    mbf_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_GRAD  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_FETCH = 3'd6;

    cfg_t cfg;

    mbf_cfg u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .cfg
    );

    logic [2:0] state_reg, state_next;
    logic [SLOT_W:0] idx_reg;
    logic [SLOT_W:0] n_eff;
    logic signed [31:0] qx_reg, qy_reg, qz_reg;
    logic out_valid_reg;
    logic signed [47:0] out_density_reg;
    logic out_inside_reg, out_surf_reg;

    logic accept;
    logic we;
    logic [ENTRY_W-1:0] rdata;
    logic ev_start, ev_clear, ev_done;
    logic signed [47:0] dens, gx, gy, gz;

    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept = in_ch.valid && in_ch.ready;
    // drop writes beyond the table
    assign we = accept && (in_ch.action == ACT_WRITE)
              && (32'(in_ch.slot) < MAX_ELEMENTS);

    always_comb
    begin
        if (32'(cfg.count) > MAX_ELEMENTS)
            n_eff = (SLOT_W+1)'(MAX_ELEMENTS);
        else
            n_eff = (SLOT_W+1)'(cfg.count);
    end

    mbf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ELEMENTS)) u_table (
        .clk,
        .we,
        .waddr (SLOT_W'(in_ch.slot)),
        .wdata ({in_ch.coef_constant, in_ch.coef_quadratic, in_ch.coef_quartic,
                 in_ch.reach_sq, in_ch.coord_z, in_ch.coord_y, in_ch.coord_x}),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata
    );

    mbf_eval u_eval (
        .clk, .rst_n,
        .start (ev_start),
        .clear (ev_clear),
        .entry (rdata),
        .qx (qx_reg), .qy (qy_reg), .qz (qz_reg),
        .done (ev_done),
        .density (dens), .gx, .gy, .gz
    );

    assign ev_clear = accept;
    assign ev_start = (state_reg == ST_READ) && (idx_reg < n_eff);

    // surface test: squared gradient length against epsilon
    logic [47:0] mx, my, mz;
    logic big;
    logic [65:0] gsq;
    logic in_flag;
    always_comb
    begin
        mx = gx[47] ? 48'(-gx) : 48'(gx);
        my = gy[47] ? 48'(-gy) : 48'(gy);
        mz = gz[47] ? 48'(-gz) : 48'(gz);
        big = (mx[47:32] != 0) || (my[47:32] != 0) || (mz[47:32] != 0);
        gsq = 66'({32'd0, mx[31:0]} * {32'd0, mx[31:0]})
            + 66'({32'd0, my[31:0]} * {32'd0, my[31:0]})
            + 66'({32'd0, mz[31:0]} * {32'd0, mz[31:0]});
        in_flag = (49'(dens) > (49'(cfg.threshold) - $signed({33'd0, cfg.margin})))
                ^ cfg.inverted;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = (in_ch.action == ACT_WRITE) ? ST_WAIT : ST_FETCH;
            // hold in ST_FETCH while the table row for idx_reg is read
            ST_FETCH: state_next = ST_READ;
            ST_READ:  state_next = (idx_reg < n_eff) ? ST_EVAL : ST_GRAD;
            ST_EVAL:  if (ev_done) state_next = ST_FETCH;
            ST_GRAD:  state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            ST_WAIT:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                idx_reg <= '0;
            else if (state_reg == ST_EVAL && ev_done)
                idx_reg <= idx_reg + 1'b1;
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_OUT || state_reg == ST_WAIT)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg <= in_ch.coord_x;
            qy_reg <= in_ch.coord_y;
            qz_reg <= in_ch.coord_z;
        end
        if (state_reg == ST_WAIT)
        begin
            out_density_reg <= '0;
            out_inside_reg  <= 1'b0;
            out_surf_reg    <= 1'b0;
        end
        if (state_reg == ST_GRAD)
        begin
            out_density_reg <= dens;
            out_inside_reg  <= in_flag;
            out_surf_reg    <= big || (gsq >= (66'(cfg.epsilon) << 16));
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.density       = out_density_reg;
    assign out_ch.inside_res    = out_inside_reg;
    assign out_ch.surface_valid = out_surf_reg;
endmodule
